// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the escape decoder.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// The expression must never be true at a clock edge outside reset.
`define AST_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/ced_pkg.sv =====
// Types and constants shared by the escape decoder modules.
// No dependencies.
`timescale 1ns / 1ps

package ced_pkg;

    // Decoder modes.
    typedef enum logic [2:0] {
        MODE_TEXT = 3'd0,
        MODE_ESC  = 3'd1,
        MODE_HEX0 = 3'd2,
        MODE_HEX1 = 3'd3,
        MODE_OCT1 = 3'd4,
        MODE_OCT2 = 3'd5
    } t_mode;

    // Characters with a special role.
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_CHAR_X = 8'h78;
    localparam logic [7:0] C_DIGIT0 = 8'h30;
    localparam logic [7:0] C_DIGIT7 = 8'h37;

    // All results caused by one input beat: up to two data bytes,
    // then optionally the end marker.
    typedef struct packed {
        logic [1:0] n_data;
        logic [7:0] data0;
        logic [7:0] data1;
        logic       has_end;
    } t_bundle;

endpackage

// ===== hw/rtl/ced_front.sv =====
// Front end of the escape decoder: accepts input beats, tracks the escape mode
// and forms one result bundle per beat. Depends on ced_pkg.
`timescale 1ns / 1ps

module ced_front
    import ced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_bundle    o_bundle
);

    t_mode      r_mode, n_mode;
    logic [7:0] r_pend, n_pend;
    logic       r_str_ended, n_str_ended;

    logic       accept;
    logic       ended;
    logic       text_go;
    logic       e1_v, e2_v, e3_v;
    logic [7:0] e1, e2, e3;
    logic [4:0] hex;
    logic       is_oct;

    // Bit 4 flags a hex digit, the low nibble is its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, b[3:0]};
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign accept     = i_in_valid && !i_queue_full;
    assign o_in_ready = !i_queue_full;
    assign hex        = hex_digit(i_data_byte);
    assign is_oct     = (i_data_byte >= C_DIGIT0) && (i_data_byte <= C_DIGIT7);

    always_comb begin
        n_mode      = r_mode;
        n_pend      = r_pend;
        n_str_ended = r_str_ended;
        ended       = 1'b0;
        text_go     = 1'b0;
        e1_v = 1'b0; e1 = 8'h00;
        e2_v = 1'b0; e2 = 8'h00;
        e3_v = 1'b0; e3 = 8'h00;

        if (r_str_ended) begin
            if (i_last_byte) begin
                n_str_ended = 1'b0;
            end
        end else begin
            unique case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_TEXT;
                    unique case (i_data_byte)
                        C_NUL:    ended = 1'b1;
                        "v":      begin e1_v = 1'b1; e1 = 8'h0B; end
                        "f":      begin e1_v = 1'b1; e1 = 8'h0C; end
                        "t":      begin e1_v = 1'b1; e1 = 8'h09; end
                        "n":      begin e1_v = 1'b1; e1 = 8'h0A; end
                        "r":      begin e1_v = 1'b1; e1 = 8'h0D; end
                        "a":      begin e1_v = 1'b1; e1 = 8'h07; end
                        "b":      begin e1_v = 1'b1; e1 = 8'h08; end
                        C_BSLASH: begin e1_v = 1'b1; e1 = C_BSLASH; end
                        C_CHAR_X: n_mode = MODE_HEX0;
                        default: begin
                            if (is_oct) begin
                                n_pend = {5'd0, i_data_byte[2:0]};
                                n_mode = MODE_OCT1;
                            end else begin
                                e1_v = 1'b1;
                                e1   = i_data_byte;
                            end
                        end
                    endcase
                end
                MODE_HEX0: begin
                    if (hex[4]) begin
                        n_pend = {4'd0, hex[3:0]};
                        n_mode = MODE_HEX1;
                    end else begin
                        e1_v    = 1'b1;
                        e1      = C_CHAR_X;
                        text_go = 1'b1;
                    end
                end
                MODE_HEX1: begin
                    e1_v = 1'b1;
                    if (hex[4]) begin
                        e1     = {r_pend[3:0], hex[3:0]};
                        n_mode = MODE_TEXT;
                    end else begin
                        e1      = r_pend;
                        text_go = 1'b1;
                    end
                end
                MODE_OCT1: begin
                    if (is_oct) begin
                        n_pend = {r_pend[4:0], i_data_byte[2:0]};
                        n_mode = MODE_OCT2;
                    end else begin
                        e1_v    = 1'b1;
                        e1      = r_pend;
                        text_go = 1'b1;
                    end
                end
                MODE_OCT2: begin
                    e1_v = 1'b1;
                    if (is_oct) begin
                        e1     = {r_pend[4:0], i_data_byte[2:0]};
                        n_mode = MODE_TEXT;
                    end else begin
                        e1      = r_pend;
                        text_go = 1'b1;
                    end
                end
                default: text_go = 1'b1;
            endcase

            // Ordinary text handling of the current byte.
            if (text_go) begin
                n_mode = MODE_TEXT;
                if (i_data_byte == C_NUL) begin
                    ended = 1'b1;
                end else if (i_data_byte == C_BSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    e2_v = 1'b1;
                    e2   = i_data_byte;
                end
            end

            // Flush whatever is pending when the string runs out.
            if (!ended && i_last_byte) begin
                if (n_mode == MODE_HEX0) begin
                    e3_v = 1'b1;
                    e3   = C_CHAR_X;
                end else if (n_mode == MODE_HEX1 || n_mode == MODE_OCT1 ||
                             n_mode == MODE_OCT2) begin
                    e3_v = 1'b1;
                    e3   = n_pend;
                end
                ended = 1'b1;
            end

            if (ended) begin
                n_mode      = MODE_TEXT;
                n_pend      = 8'h00;
                n_str_ended = !i_last_byte;
            end
        end
    end

    // The flush result only occurs when nothing else was emitted, so at
    // most two data bytes arise and they pack in order.
    always_comb begin
        o_bundle.data0   = e1_v ? e1 : (e2_v ? e2 : e3);
        o_bundle.data1   = e2;
        o_bundle.n_data  = {1'b0, e1_v} + {1'b0, e2_v} + {1'b0, e3_v};
        o_bundle.has_end = ended;
    end

    assign o_push = accept && (e1_v || e2_v || e3_v || ended);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_TEXT;
            r_pend      <= 8'h00;
            r_str_ended <= 1'b0;
        end else if (accept) begin
            r_mode      <= n_mode;
            r_pend      <= n_pend;
            r_str_ended <= n_str_ended;
        end
    end

endmodule

// ===== hw/rtl/ced_queue.sv =====
// Short bundle queue between the front end and the output serialiser.
// Depends on ced_pkg and assert_macros.svh.
`timescale 1ns / 1ps

module ced_queue
    import ced_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_bundle i_bundle,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_head_valid,
    output t_bundle o_head
);

`include "assert_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_bundle          r_entries [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == FULL_CNT);
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_entries[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `AST_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into a full queue")
    `AST_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_head_valid, "pop from an empty queue")
    `AST_HOLDS(a_pop_count, i_clk, i_rst_n, (i_pop && !i_push) |=> (r_count == $past(r_count) - 1'b1), "queue count did not drop on pop")

endmodule

// ===== hw/rtl/ced_back.sv =====
// Output serialiser: walks the head bundle one result per cycle, while the
// receiver is not stalling, into the output register. Depends on ced_pkg.
`timescale 1ns / 1ps

module ced_back
    import ced_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_bundle    i_head,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_end,
    output logic       o_last_of_run
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_end;
    logic       r_last;

    logic       load;
    logic [1:0] total;
    logic       res_last;
    logic       res_data;
    logic [7:0] res_byte;

    assign load     = i_head_valid && (!r_valid || i_out_ready);
    assign total    = i_head.n_data + {1'b0, i_head.has_end};
    assign res_last = (r_idx == total - 2'd1);
    assign res_data = (r_idx < i_head.n_data);
    assign res_byte = !res_data ? 8'h00 : ((r_idx == 2'd0) ? i_head.data0 : i_head.data1);
    assign o_pop    = load && res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= res_last ? 2'd0 : r_idx + 2'd1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= res_byte;
            r_end  <= !res_data;
            r_last <= res_last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_is_end      = r_end;
    assign o_last_of_run = r_last;

endmodule

// ===== hw/rtl/c_escape_decoder.sv =====
// Top level of the streaming C string escape decoder.
// Depends on ced_pkg, ced_front, ced_queue and ced_back.
`timescale 1ns / 1ps

// The decoder takes one raw string byte per input beat, with a flag on the
// final byte, and returns the decoded bytes followed by one end-marker result
// per string. The input side accepts a byte in every cycle while the bundle
// queue has room; the output side delivers one result per cycle while the
// receiver is ready, so a byte that yields k results (k is at most three, for
// instance a pending octal value, the byte itself and the end marker) holds
// the serialiser until all k are out, and with a ready receiver the sustained
// rate is one byte per cycle whenever bytes yield at most one result each.
// Bytes that only advance the escape state, and bytes that follow a NUL inside
// the same string, produce nothing and never reach the queue. A byte's first
// result passes through the bundle queue and then the output register.
// QUEUE_DEPTH sets how many bundles may wait between the front end and the
// serialiser; it must be at least two to keep the input running at full rate.
module c_escape_decoder
    import ced_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_is_end,
    output logic       o_last_of_run
);

    // Bundle handed from the front end to the queue on each productive beat.
    logic    push;
    t_bundle push_bundle;
    logic    queue_full;

    // Head of the queue as seen by the serialiser.
    logic    pop;
    logic    head_valid;
    t_bundle head;

    // The front end owns the escape state and classifies every byte.
    ced_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_bundle     (push_bundle)
    );

    // The queue lets the front end keep accepting while results drain.
    ced_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_bundle     (push_bundle),
        .o_full       (queue_full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // The serialiser emits one result per cycle, while the receiver is not stalling, through a registered output.
    ced_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (head_valid),
        .i_head        (head),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_is_end      (o_is_end),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== verif/c_escape_decoder_tb.sv =====
// Self-checking testbench for the streaming C string escape decoder.
// Depends on ced_pkg and c_escape_decoder; drives random and directed strings.
`timescale 1ns / 1ps

module c_escape_decoder_tb;
    import ced_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 10;
    localparam int RANDOM_BEATS   = 380;

    // One decoded result as it should appear on the output side.
    typedef struct packed {
        logic [7:0] value;
        logic       is_end;
        logic       last_of_run;
    } t_decoded;

    // The scoreboard mirrors the decoder state and keeps the decoded results
    // still owed by the block, oldest first.
    class decode_checker;
        t_mode      mode;
        logic [7:0] held;
        bit         skipping;
        t_decoded   owed_q[$];
        t_decoded   beat_q[$];
        int         errors;
        int         n_results;
        int         n_markers;

        function new();
            mode      = MODE_TEXT;
            held      = 8'h00;
            skipping  = 1'b0;
            errors    = 0;
            n_results = 0;
            n_markers = 0;
        endfunction

        task report(input string msg);
            $display("MISMATCH at %0t ns: %s", $time, msg);
            errors++;
        endtask

        function void add(input logic [7:0] value, input bit marker);
            t_decoded r;
            r.value       = value;
            r.is_end      = marker;
            r.last_of_run = 1'b0;
            beat_q.push_back(r);
        endfunction

        function int hex_value(input logic [7:0] b);
            if (b >= "0" && b <= "9") return int'(b) - int'("0");
            if (b >= "a" && b <= "f") return int'(b) - int'("a") + 10;
            if (b >= "A" && b <= "F") return int'(b) - int'("A") + 10;
            return -1;
        endfunction

        function bit is_octal(input logic [7:0] b);
            return b >= C_DIGIT0 && b <= C_DIGIT7;
        endfunction

        // Plain text handling; returns 1 when the byte terminates the string.
        function bit text_char(input logic [7:0] b);
            mode = MODE_TEXT;
            if (b == C_NUL) return 1'b1;
            if (b == C_BSLASH) mode = MODE_ESC;
            else add(b, 1'b0);
            return 1'b0;
        endfunction

        // The byte right after a backslash.
        function bit escaped_char(input logic [7:0] b);
            mode = MODE_TEXT;
            case (b)
                C_NUL:    return 1'b1;
                "v":      add(8'h0B, 1'b0);
                "f":      add(8'h0C, 1'b0);
                "t":      add(8'h09, 1'b0);
                "n":      add(8'h0A, 1'b0);
                "r":      add(8'h0D, 1'b0);
                "a":      add(8'h07, 1'b0);
                "b":      add(8'h08, 1'b0);
                C_BSLASH: add(C_BSLASH, 1'b0);
                C_CHAR_X: mode = MODE_HEX0;
                default: begin
                    if (is_octal(b)) begin
                        held = b - C_DIGIT0;
                        mode = MODE_OCT1;
                    end else begin
                        add(b, 1'b0);
                    end
                end
            endcase
            return 1'b0;
        endfunction

        // Works out every result that one accepted input beat causes.
        function void decode_beat(input logic [7:0] b, input bit last);
            bit         ended;
            int         h;
            logic [7:0] v;
            t_decoded   r;
            ended = 1'b0;
            beat_q.delete();
            if (skipping) begin
                // Bytes after an early NUL are swallowed until the final byte.
                if (last) skipping = 1'b0;
                return;
            end
            h = hex_value(b);
            case (mode)
                MODE_ESC: ended = escaped_char(b);
                MODE_HEX0: begin
                    if (h >= 0) begin
                        held = h[7:0];
                        mode = MODE_HEX1;
                    end else begin
                        add(C_CHAR_X, 1'b0);
                        ended = text_char(b);
                    end
                end
                MODE_HEX1: begin
                    if (h >= 0) begin
                        v = {held[3:0], h[3:0]};
                        add(v, 1'b0);
                        mode = MODE_TEXT;
                    end else begin
                        add(held, 1'b0);
                        ended = text_char(b);
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (is_octal(b)) begin
                        v = (held << 3) + (b - C_DIGIT0);
                        if (mode == MODE_OCT1) begin
                            held = v;
                            mode = MODE_OCT2;
                        end else begin
                            add(v, 1'b0);
                            mode = MODE_TEXT;
                        end
                    end else begin
                        add(held, 1'b0);
                        ended = text_char(b);
                    end
                end
                default: ended = text_char(b);
            endcase
            if (!ended && last) begin
                // A value still being collected is flushed at the end.
                if (mode == MODE_HEX0) add(C_CHAR_X, 1'b0);
                else if (mode != MODE_TEXT && mode != MODE_ESC) add(held, 1'b0);
                ended = 1'b1;
            end
            if (ended) begin
                add(8'h00, 1'b1);
                mode     = MODE_TEXT;
                held     = 8'h00;
                skipping = !last;
            end
            if (beat_q.size() > 0) begin
                r = beat_q[beat_q.size() - 1];
                r.last_of_run = 1'b1;
                beat_q[beat_q.size() - 1] = r;
            end
            foreach (beat_q[i]) owed_q.push_back(beat_q[i]);
        endfunction

        task check_result(input logic [7:0] value, input logic marker, input logic tail);
            t_decoded e;
            if (owed_q.size() == 0) begin
                report($sformatf("result %02h end=%0b with none owed", value, marker));
                return;
            end
            e = owed_q.pop_front();
            n_results++;
            if (marker) n_markers++;
            if (value !== e.value)
                report($sformatf("out_byte %02h, wanted %02h", value, e.value));
            if (marker !== e.is_end)
                report($sformatf("is_end %0b, wanted %0b", marker, e.is_end));
            if (tail !== e.last_of_run)
                report($sformatf("last_of_run %0b, wanted %0b", tail, e.last_of_run));
        endtask

        function int owed();
            return owed_q.size();
        endfunction
    endclass

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_in_valid   = 1'b0;
    logic [7:0] i_data_byte  = 8'h00;
    logic       i_last_byte  = 1'b0;
    logic       i_out_ready  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_is_end;
    logic       o_last_of_run;

    decode_checker sb = new();
    logic [7:0]    str_q[$];
    int            beats_sent  = 0;
    int            stall_left  = 0;
    int            quiet_count = 0;
    bit            idling      = 1'b1;

    c_escape_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_data_byte   (i_data_byte),
        .i_last_byte   (i_last_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_is_end      (o_is_end),
        .o_last_of_run (o_last_of_run)
    );

    always #6 i_clk = ~i_clk;

    // The receiver stalls in random bursts while idling is on.
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= (stall_left == 1);
        end else if (idling && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 5);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Both handshakes are sampled here, before any of this edge's updates land.
    // The watchdog counts cycles in which neither side moves a beat.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_result(o_out_byte, o_is_end, o_last_of_run);
            if (i_in_valid && o_in_ready)
                sb.decode_beat(i_data_byte, i_last_byte);
            if ((o_out_valid && i_out_ready) || (i_in_valid && o_in_ready)) begin
                quiet_count <= 0;
            end else begin
                quiet_count <= quiet_count + 1;
                if (quiet_count >= WATCHDOG_LIMIT) begin
                    $display("Watchdog expired after %0d quiet cycles.", WATCHDOG_LIMIT);
                    $display("Simulation FAILED");
                    $finish;
                end
            end
        end
    end

    // Presents one byte and holds it until the decoder takes it. A random
    // gap may follow, during which valid is low.
    task automatic send_beat(input logic [7:0] b, input bit last);
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        idling = (beats_sent < 100) || (beats_sent >= 160 && beats_sent < 320);
        if (idling && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], close && (i == s.len() - 1));
    endtask

    // Holds the input off until every owed result has been delivered.
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.owed() != 0);
    endtask

    function automatic logic [7:0] hex_char(input int v, input bit upper);
        if (v < 10) return C_DIGIT0 + 8'(v);
        return (upper ? "A" : "a") + 8'(v - 10);
    endfunction

    // Appends one random piece of escaped text to the string being built.
    task automatic add_token();
        string      esc_set;
        int         kind;
        logic [7:0] b;
        esc_set = "vftnrab\\";
        kind    = $urandom_range(0, 9);
        case (kind)
            0, 1, 2: begin
                b = 8'($urandom_range(1, 255));
                str_q.push_back(b == C_BSLASH ? 8'h41 : b);
            end
            3: begin
                str_q.push_back(C_BSLASH);
                str_q.push_back(esc_set[$urandom_range(0, 7)]);
            end
            4: begin
                str_q.push_back(C_BSLASH);
                str_q.push_back(C_CHAR_X);
                repeat ($urandom_range(1, 2))
                    str_q.push_back(hex_char($urandom_range(0, 15),
                                             1'($urandom_range(0, 1))));
            end
            5: begin
                str_q.push_back(C_BSLASH);
                repeat ($urandom_range(1, 3))
                    str_q.push_back(C_DIGIT0 + 8'($urandom_range(0, 7)));
            end
            6: begin
                str_q.push_back(C_BSLASH);
                str_q.push_back(8'($urandom_range(1, 255)));
            end
            7: begin
                // A bare \x: whatever follows decides what becomes of it.
                str_q.push_back(C_BSLASH);
                str_q.push_back(C_CHAR_X);
            end
            8: begin
                str_q.push_back(C_BSLASH);
                str_q.push_back($urandom_range(0, 1) ? "8" : "9");
            end
            default: str_q.push_back(hex_char($urandom_range(0, 15),
                                              1'($urandom_range(0, 1))));
        endcase
    endtask

    // Builds one string with a random ending and sends it, the last byte flagged.
    task automatic send_random_string();
        int style;
        str_q.delete();
        repeat ($urandom_range(1, 6)) add_token();
        style = $urandom_range(0, 9);
        case (style)
            6: begin
                // Early NUL: the bytes after it are swallowed.
                str_q.push_back(C_NUL);
                repeat ($urandom_range(0, 3)) str_q.push_back(8'($urandom_range(0, 255)));
                str_q.push_back(8'($urandom_range(0, 255)));
            end
            7: str_q.push_back(C_NUL);
            8: str_q.push_back(C_BSLASH);
            9: begin
                str_q.push_back(C_BSLASH);
                str_q.push_back(C_NUL);
                repeat ($urandom_range(0, 2)) str_q.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        foreach (str_q[i]) send_beat(str_q[i], i == str_q.size() - 1);
    endtask

    initial begin
        bit drained;
        drained = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings: \n and an escaped backslash, hex and octal values with
        // a truncated \777, a hex value flushed by the end of the string, a byte
        // of all ones, an early NUL with swallowed bytes behind it, \8, a bare
        // \x followed by a backslash and NUL, and a lone trailing backslash.
        send_text("\\n\\\\\\x4F\\777", 1'b1);
        send_text("\\xa", 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(C_NUL, 1'b0);
        send_beat("z", 1'b0);
        send_beat("q", 1'b1);
        send_text("\\8\\x\\", 1'b0);
        send_beat(C_NUL, 1'b1);
        send_text("\\", 1'b1);

        // Random part: mostly well-formed strings, some raw noise whose last
        // flags fall anywhere.
        while (beats_sent < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6))
                    send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                send_random_string();
            end
            if (!drained && beats_sent >= 200) begin
                drain();
                drained = 1'b1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.owed() != 0)
            sb.report($sformatf("%0d results never arrived", sb.owed()));

        $display("Sent %0d input bytes; checked %0d decoded results, %0d of them end markers.",
                 beats_sent, sb.n_results, sb.n_markers);
        if (sb.errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches found.", sb.errors);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/ced_pkg.sv
hw/rtl/ced_front.sv
hw/rtl/ced_queue.sv
hw/rtl/ced_back.sv
hw/rtl/c_escape_decoder.sv
verif/c_escape_decoder_tb.sv
